FILE: hw/rtl/idr_pkg.sv
// Shared definitions for the interpolated delay ring.
// Holds parameter defaults, fixed field widths, opcode and sequencer state types.
// No dependencies.
package idr_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_SAMPLES_DEF     = 4096;
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int DELAY_FRAC_BITS_DEF = 8;

  // Field widths fixed by the interface.
  localparam int OPCODE_W = 2;
  localparam int DELAY_W  = 20;
  localparam int CFG_W    = 13;

  // Operation codes carried on the input channel.
  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE = 2'd0,
    OP_ACC   = 2'd1,
    OP_READ  = 2'd2,
    OP_DELAY = 2'd3
  } op_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_RDATA,
    ST_MOD,
    ST_ADDR,
    ST_RD1,
    ST_MUL,
    ST_INTERP,
    ST_FINISH
  } state_t;

endpackage

FILE: hw/rtl/interpolated_delay_ring.sv
// Interpolated delay ring: a circular store of signed fixed-point samples, its length in use set
// by cfg_buffer_length, with separate write, accumulate and read cursors. One beat is taken at
// a time. An accumulate reads then writes back; a delayed interpolated read first reduces the
// integer delay modulo the length by a restoring remainder unit at one bit per cycle, then
// the two neighbouring samples are read in turn through the single read port, multiplied by
// the fraction and rounded. After reset the store is cleared one entry per cycle; no input
// beat is taken meanwhile, though configuration writes are.
// A finished result waits in an output register, so the next input beat can be taken while
// it is outstanding. Depends on idr_pkg and idr_ram.
module interpolated_delay_ring
  import idr_pkg::*;
#(
  parameter int MAX_SAMPLES     = MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int DELAY_FRAC_BITS = DELAY_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [OPCODE_W-1:0]           in_opcode,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic [DELAY_W-1:0]            in_delay,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          cfg_wr_en,
  input  logic [CFG_W-1:0]              cfg_buffer_length
);

  localparam int SW    = SAMPLE_BITS;
  localparam int F     = DELAY_FRAC_BITS;
  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int LEN_W = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam int IW    = DELAY_W - F;
  localparam int CNT_W = $clog2(IW);
  localparam int PRW   = SW + F + 2;
  localparam int PW    = PRW + 1;
  localparam int RND   = 1 << (F - 1);
  localparam longint SMAX = (64'sd1 <<< (SW - 1)) - 64'sd1;
  localparam longint SMIN = -SMAX - 64'sd1;

  // Registers.
  state_t                 state_r, state_nxt;
  logic [AW-1:0]          clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]          wr_cur_r, wr_cur_nxt;
  logic [AW-1:0]          acc_cur_r, acc_cur_nxt;
  logic [AW-1:0]          rd_cur_r, rd_cur_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [AW-1:0]          pos_r, pos_nxt;
  logic signed [SW-1:0]   sample_r, sample_nxt;
  logic [IW-1:0]          quo_r, quo_nxt;
  logic [F-1:0]           frac_r, frac_nxt;
  logic [LEN_W-1:0]       rem_r, rem_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [AW-1:0]          x1_r, x1_nxt;
  logic signed [SW-1:0]   y0_r, y0_nxt;
  logic signed [PRW-1:0]  prod_r, prod_nxt;
  logic signed [SW-1:0]   res_r, res_nxt;
  logic signed [SW-1:0]   out_sample_r, out_sample_nxt;

  // Memory port signals.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [SW-1:0] ram_rdata;

  // Datapath signals.
  op_t                  in_op;
  logic [AW-1:0]        cur_sel;
  logic [AW-1:0]        take_pos;
  logic [LEN_W-1:0]     take_step;
  logic [AW-1:0]        take_next;
  logic signed [SW:0]   acc_sum;
  logic [SW-1:0]        acc_sat;
  logic [LEN_W:0]       rem_try;
  logic [LEN_W:0]       len_ext;
  logic [LEN_W-1:0]     rem_step;
  logic [LEN_W-1:0]     x0_full;
  logic [AW-1:0]        x0;
  logic [AW-1:0]        x1;
  logic signed [SW:0]   diff;
  logic signed [F:0]    frac_s;
  logic signed [PW-1:0] rnd_p;
  logic signed [PW-1:0] shifted;
  logic signed [PW-1:0] interp;
  logic signed [SW-1:0] interp_sat;
  logic                 out_load;
  logic [CMP_W-1:0]     cfg_wide;

  idr_ram #(
    .WIDTH(SW),
    .DEPTH(MAX_SAMPLES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_op = op_t'(in_opcode);

  // Cursor selection and stepping; a cursor past the length acts as zero.
  always_comb begin
    unique case (in_op)
      OP_WRITE: cur_sel = wr_cur_r;
      OP_ACC:   cur_sel = acc_cur_r;
      default:  cur_sel = rd_cur_r;
    endcase
    take_pos  = (LEN_W'(cur_sel) < len_r) ? cur_sel : '0;
    take_step = LEN_W'(take_pos) + LEN_W'(1);
    take_next = (take_step >= len_r) ? '0 : AW'(take_step);
  end

  // Saturating accumulate of the stored sample and the held input sample.
  always_comb begin
    acc_sum = $signed({ram_rdata[SW-1], ram_rdata}) + $signed({sample_r[SW-1], sample_r});
    if (acc_sum[SW] != acc_sum[SW-1]) begin
      acc_sat = acc_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[SW-1:0];
    end
  end

  // One step of the restoring remainder: the partial remainder stays below the length.
  always_comb begin
    rem_try  = {rem_r, quo_r[IW-1]};
    len_ext  = (LEN_W+1)'(len_r);
    rem_step = (rem_try >= len_ext) ? LEN_W'(rem_try - len_ext) : LEN_W'(rem_try);
  end

  // Newer and older neighbour positions behind the read position.
  always_comb begin
    x0_full = LEN_W'(pos_r) - rem_r;
    if (LEN_W'(pos_r) < rem_r) begin
      x0_full = x0_full + len_r;
    end
    x0 = AW'(x0_full);
    x1 = (x0_full == '0) ? AW'(len_r - LEN_W'(1)) : AW'(x0_full - LEN_W'(1));
  end

  // Interpolation: product of difference and fraction, then rounding and saturation.
  always_comb begin
    diff    = $signed({ram_rdata[SW-1], ram_rdata}) - $signed({y0_r[SW-1], y0_r});
    frac_s  = $signed({1'b0, frac_r});
    rnd_p   = PW'(prod_r) + PW'(RND);
    shifted = rnd_p >>> F;
    interp  = shifted + PW'(y0_r);
    if (interp > PW'(SMAX)) begin
      interp_sat = SW'(SMAX);
    end else if (interp < PW'(SMIN)) begin
      interp_sat = SW'(SMIN);
    end else begin
      interp_sat = SW'(interp);
    end
  end

  // Length register: zero acts as one, anything above the store size as the store size.
  always_comb begin
    cfg_wide = CMP_W'(cfg_buffer_length);
    len_nxt  = len_r;
    if (cfg_wr_en) begin
      priority if (cfg_wide == '0) begin
        len_nxt = LEN_W'(1);
      end else if (cfg_wide > CMP_W'(MAX_SAMPLES)) begin
        len_nxt = LEN_W'(MAX_SAMPLES);
      end else begin
        len_nxt = LEN_W'(cfg_wide);
      end
    end
  end

  // Sequencer: next state, memory port control and datapath register loads.
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    wr_cur_nxt   = wr_cur_r;
    acc_cur_nxt  = acc_cur_r;
    rd_cur_nxt   = rd_cur_r;
    pos_nxt      = pos_r;
    sample_nxt   = sample_r;
    quo_nxt      = quo_r;
    frac_nxt     = frac_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    x1_nxt       = x1_r;
    y0_nxt       = y0_r;
    prod_nxt     = prod_r;
    res_nxt      = res_r;
    out_load     = 1'b0;
    in_ready     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = pos_r;
    ram_wdata    = sample_r;
    ram_raddr    = pos_r;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MAX_SAMPLES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = take_pos;
        if (in_valid) begin
          pos_nxt    = take_pos;
          sample_nxt = in_sample_in;
          quo_nxt    = in_delay[DELAY_W-1:F];
          frac_nxt   = in_delay[F-1:0];
          rem_nxt    = '0;
          cnt_nxt    = '0;
          unique case (in_op)
            OP_WRITE: begin
              ram_we     = 1'b1;
              ram_waddr  = take_pos;
              ram_wdata  = in_sample_in;
              wr_cur_nxt = take_next;
            end
            OP_ACC: begin
              acc_cur_nxt = take_next;
              state_nxt   = ST_ACC;
            end
            OP_READ: begin
              rd_cur_nxt = take_next;
              state_nxt  = ST_RDATA;
            end
            OP_DELAY: begin
              rd_cur_nxt = take_next;
              state_nxt  = ST_MOD;
            end
          endcase
        end
      end
      ST_ACC: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = acc_sat;
        state_nxt = ST_IDLE;
      end
      ST_RDATA: begin
        res_nxt   = ram_rdata;
        state_nxt = ST_FINISH;
      end
      ST_MOD: begin
        rem_nxt = rem_step;
        quo_nxt = quo_r << 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(IW - 1)) begin
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: begin
        ram_raddr = x0;
        x1_nxt    = x1;
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        ram_raddr = x1_r;
        y0_nxt    = ram_rdata;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt  = diff * frac_s;
        state_nxt = ST_INTERP;
      end
      ST_INTERP: begin
        res_nxt   = interp_sat;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: a loaded result waits until the beat is taken.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = res_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      wr_cur_r    <= '0;
      acc_cur_r   <= '0;
      rd_cur_r    <= '0;
      len_r       <= LEN_W'(MAX_SAMPLES);
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      wr_cur_r    <= wr_cur_nxt;
      acc_cur_r   <= acc_cur_nxt;
      rd_cur_r    <= rd_cur_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    sample_r     <= sample_nxt;
    quo_r        <= quo_nxt;
    frac_r       <= frac_nxt;
    rem_r        <= rem_nxt;
    x1_r         <= x1_nxt;
    y0_r         <= y0_nxt;
    prod_r       <= prod_nxt;
    res_r        <= res_nxt;
    out_sample_r <= out_sample_nxt;
  end

endmodule

FILE: hw/rtl/idr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Used for the sample store of the delay ring. No dependencies.
module idr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: dv/delay_ring_checker.sv
`timescale 1ns / 1ps
// Checker for the interpolated delay ring: watches the input, result and configuration ports,
// keeps its own copy of the ring and its cursors, and compares every result beat in order.
// Depends on idr_pkg.
module delay_ring_checker
  import idr_pkg::*;
(
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [OPCODE_W-1:0]               in_opcode,
  input  logic signed [SAMPLE_BITS_DEF-1:0] in_sample_in,
  input  logic [DELAY_W-1:0]                in_delay,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [SAMPLE_BITS_DEF-1:0] out_sample_out,
  input  logic                              cfg_wr_en,
  input  logic [CFG_W-1:0]                  cfg_buffer_length,
  output int                                fail_count,
  output int                                pending_results
);

  localparam int DEPTH   = MAX_SAMPLES_DEF;
  localparam int SBITS   = SAMPLE_BITS_DEF;
  localparam int FRAC    = DELAY_FRAC_BITS_DEF;
  localparam int SMP_TOP = 2 ** (SBITS - 1) - 1;
  localparam int SMP_BOT = -SMP_TOP - 1;

  logic signed [SBITS-1:0] ring_copy [DEPTH];
  int                      write_pos;
  int                      acc_pos;
  int                      read_pos;
  logic [CFG_W-1:0]        length_reg;
  logic signed [SBITS-1:0] expected_samples [$];
  logic signed [SBITS-1:0] oldest_sample;

  // A length of zero behaves as one, anything above the store size as the store size.
  function automatic int span_of(logic [CFG_W-1:0] value);
    if (value == 0) return 1;
    if (value > DEPTH) return DEPTH;
    return int'(value);
  endfunction

  // A cursor left beyond a shortened ring restarts at the first entry.
  function automatic int cursor_here(int cursor, int span);
    return (cursor < span) ? cursor : 0;
  endfunction

  function automatic int cursor_after(int here, int span);
    return (here + 1 >= span) ? 0 : here + 1;
  endfunction

  // Applies one accepted input beat to the ring copy and queues the sample it returns.
  task automatic apply_beat(logic [OPCODE_W-1:0] opcode, logic signed [SBITS-1:0] smp,
                            logic [DELAY_W-1:0] dly);
    int span, here, sum, whole, frac, x0, x1, y0, y1, prod, y;
    span = span_of(length_reg);
    case (op_t'(opcode))
      OP_WRITE: begin
        here = cursor_here(write_pos, span);
        write_pos = cursor_after(here, span);
        ring_copy[here] = smp;
      end
      OP_ACC: begin
        here = cursor_here(acc_pos, span);
        acc_pos = cursor_after(here, span);
        sum = int'(ring_copy[here]) + int'(smp);
        if (sum > SMP_TOP) sum = SMP_TOP;
        else if (sum < SMP_BOT) sum = SMP_BOT;
        ring_copy[here] = sum[SBITS-1:0];
      end
      OP_READ: begin
        here = cursor_here(read_pos, span);
        read_pos = cursor_after(here, span);
        expected_samples.push_back(ring_copy[here]);
      end
      default: begin
        here = cursor_here(read_pos, span);
        read_pos = cursor_after(here, span);
        // Whole delay wraps at the ring length; the fraction blends towards the older sample.
        whole = int'(dly >> FRAC) % span;
        frac = int'(dly[FRAC-1:0]);
        x0 = (here + span - whole) % span;
        x1 = (x0 == 0) ? span - 1 : x0 - 1;
        y0 = ring_copy[x0];
        y1 = ring_copy[x1];
        prod = (y1 - y0) * frac + (1 << (FRAC - 1));
        y = y0 + (prod >>> FRAC);
        if (y > SMP_TOP) y = SMP_TOP;
        else if (y < SMP_BOT) y = SMP_BOT;
        expected_samples.push_back(y[SBITS-1:0]);
      end
    endcase
  endtask

  // Result beats are compared before the input beat of the same edge is applied.
  // An input beat taken at the edge of a length write still sees the old length.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) ring_copy[k] = '0;
      write_pos = 0;
      acc_pos = 0;
      read_pos = 0;
      length_reg = CFG_W'(DEPTH);
      expected_samples.delete();
      fail_count <= 0;
      pending_results <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: sample_out expected none, actual %0d", $time, out_sample_out);
          fail_count <= fail_count + 1;
        end else begin
          oldest_sample = expected_samples.pop_front();
          if (out_sample_out !== oldest_sample) begin
            $display("%0t: sample_out expected %0d, actual %0d", $time, oldest_sample,
                     out_sample_out);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) apply_beat(in_opcode, in_sample_in, in_delay);
      if (cfg_wr_en) length_reg = cfg_buffer_length;
      pending_results <= expected_samples.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the interpolated delay ring testbench: clock, reset, input beats, receiver stalls and
// ring length changes, with the verdict taken from the checker. Depends on idr_pkg,
// interpolated_delay_ring and delay_ring_checker.
module tb_top;
  import idr_pkg::*;

  localparam int SBITS       = SAMPLE_BITS_DEF;
  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 10;
  localparam int PHASE_BEATS = 140;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [OPCODE_W-1:0]     in_opcode = '0;
  logic signed [SBITS-1:0] in_sample_in = '0;
  logic [DELAY_W-1:0]      in_delay = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SBITS-1:0] out_sample_out;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]        cfg_buffer_length = '0;
  int                      fail_count;
  int                      pending_results;
  int                      tx_idle_pct = 0;
  int                      rx_stall_pct = 0;
  int                      cycle_count = 0;
  logic [CFG_W-1:0]        length_plan [NUM_PHASES];

  interpolated_delay_ring dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_sample_in     (in_sample_in),
    .in_delay         (in_delay),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_out   (out_sample_out),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_buffer_length(cfg_buffer_length)
  );

  delay_ring_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_sample_in     (in_sample_in),
    .in_delay         (in_delay),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_out   (out_sample_out),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_buffer_length(cfg_buffer_length),
    .fail_count       (fail_count),
    .pending_results  (pending_results)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at the rate set for the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offers one beat, after any idle cycles, and returns at the edge that accepts it.
  // Valid is left high so that a following beat can go out on the next cycle.
  task automatic send_beat(op_t op, logic signed [SBITS-1:0] smp, logic [DELAY_W-1:0] dly);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_sample_in <= smp;
    in_delay <= dly;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Holds the sender off until every result has come, then lets writes in flight settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_length(logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_buffer_length <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random beat: mostly small delays with random fractions, some full-range ones.
  task automatic send_random();
    int pick;
    op_t op;
    logic signed [SBITS-1:0] smp;
    logic [DELAY_W-1:0] dly;
    pick = $urandom_range(99);
    if (pick < 30) op = OP_WRITE;
    else if (pick < 50) op = OP_ACC;
    else if (pick < 70) op = OP_READ;
    else op = OP_DELAY;
    pick = $urandom_range(9);
    if (pick == 0) smp = 16'sh7FFF;
    else if (pick == 1) smp = 16'sh8000;
    else smp = SBITS'($urandom);
    pick = $urandom_range(9);
    if (pick < 5) dly = DELAY_W'(($urandom_range(8) << 8) | $urandom_range(255));
    else if (pick < 7) dly = DELAY_W'(($urandom_range(4200) << 8) | $urandom_range(255));
    else if (pick < 8) dly = DELAY_W'(($urandom_range(8) << 8) | (255 * $urandom_range(1)));
    else dly = DELAY_W'($urandom);
    send_beat(op, smp, dly);
  endtask

  initial begin
    length_plan = '{13'd4096, 13'd1, 13'd2, 13'd8191, 13'd0,
                    13'd5, 13'd300, 13'd3, 13'd17, 13'd4097};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats on an eight-entry ring: extremes, saturation, wrap and fraction edges.
    write_length(13'd8);
    send_beat(OP_WRITE, 16'sh7FFF, 20'h0);
    send_beat(OP_WRITE, 16'sh8000, 20'hFFFFF);
    send_beat(OP_WRITE, 16'sh0000, 20'h0);
    send_beat(OP_WRITE, 16'shFFFF, 20'h0);
    send_beat(OP_ACC, 16'sh7FFF, 20'h0);
    send_beat(OP_ACC, 16'sh8000, 20'h0);
    send_beat(OP_ACC, 16'sh0001, 20'h0);
    send_beat(OP_ACC, 16'shFFFE, 20'h0);
    send_beat(OP_READ, 16'sh0000, 20'h0);
    send_beat(OP_READ, 16'sh0000, 20'h0);
    send_beat(OP_DELAY, 16'sh0000, 20'h00000);
    send_beat(OP_DELAY, 16'sh0000, 20'h00080);
    send_beat(OP_DELAY, 16'sh0000, 20'h001FF);
    send_beat(OP_DELAY, 16'sh0000, 20'hFFFFF);
    send_beat(OP_DELAY, 16'sh0000, 20'h00801);
    send_beat(OP_DELAY, 16'sh0000, 20'h00780);
    send_beat(OP_READ, 16'sh0000, 20'h0);
    send_beat(OP_DELAY, 16'sh0000, 20'h00001);
    send_beat(OP_DELAY, 16'sh0000, 20'h000FF);
    send_beat(OP_WRITE, 16'sh1234, 20'h0);
    send_beat(OP_DELAY, 16'sh0000, 20'h00100);
    drain_results();

    // Random phases over several ring lengths, each drained before the length changes.
    for (int k = 0; k < NUM_PHASES; k++) begin
      if (k < 4) begin
        tx_idle_pct = 10;
        rx_stall_pct = 82;
      end else if (k < 7) begin
        tx_idle_pct = 82;
        rx_stall_pct = 10;
      end else begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
      write_length(length_plan[k]);
      repeat (PHASE_BEATS) send_random();
      drain_results();
    end

    @(negedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
